FILE: rtl/fcip_pkg.sv
// Shared types, codes and defaults of the firmware configuration item port.
`default_nettype none

package fcip_pkg;

    // Default geometry of the entry store.
    localparam int ENTRIES_PER_BANK_DEF = 32;
    localparam int MAX_ENTRY_BYTES_DEF  = 64;

    // Operation codes carried in the mode field.
    localparam logic [2:0] MODE_SELECT = 3'd0;
    localparam logic [2:0] MODE_READ   = 3'd1;
    localparam logic [2:0] MODE_WRITE  = 3'd2;
    localparam logic [2:0] MODE_LOAD   = 3'd3;
    localparam logic [2:0] MODE_LENGTH = 3'd4;

    // Selector key fields.
    localparam logic [15:0] KEY_WRITE_BIT  = 16'h4000;
    localparam logic [15:0] KEY_ARCH_BIT   = 16'h8000;
    localparam logic [15:0] KEY_INDEX_MASK = 16'h3fff;
    localparam logic [15:0] KEY_INVALID    = 16'hffff;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] key;
        logic [7:0]  data_byte;
        logic [5:0]  load_offset;
        logic [6:0]  entry_length;
        logic        entry_writable;
    } request_t;

    typedef struct packed {
        logic [7:0]  read_data;
        logic        write_complete;
        logic [15:0] complete_key;
    } result_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear;
        logic capture;
        logic exec;
        logic finish_read;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
        logic is_read;
    } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/fcip_ctrl.sv
// Controller state machine of the firmware configuration item port.
`default_nettype none

module fcip_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire fcip_pkg::dp_status_t status,
    output fcip_pkg::dp_cmd_t        cmd,
    output logic                     busy,
    output logic                     done
);
    import fcip_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_READ
    } state_t;

    state_t state_reg;
    logic   busy_reg;
    logic   done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:
                begin
                    done_reg <= 1'b0;
                    if (status.clear_last)
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                    end
                end
                ST_IDLE:
                begin
                    done_reg <= 1'b0;
                    if (start)
                    begin
                        state_reg <= ST_EXEC;
                        busy_reg  <= 1'b1;
                    end
                end
                ST_EXEC:
                begin
                    if (status.is_read)
                    begin
                        state_reg <= ST_READ;
                        done_reg  <= 1'b0;
                    end
                    else
                    begin
                        state_reg <= ST_IDLE;
                        busy_reg  <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_IDLE;
                    busy_reg  <= 1'b0;
                    done_reg  <= 1'b1;
                end
                default:
                begin
                    state_reg <= ST_CLEAR;
                    busy_reg  <= 1'b1;
                    done_reg  <= 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        cmd.clear       = (state_reg == ST_CLEAR);
        cmd.capture     = (state_reg == ST_IDLE) && start;
        cmd.exec        = (state_reg == ST_EXEC);
        cmd.finish_read = (state_reg == ST_READ);
    end

    assign busy = busy_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

FILE: rtl/fcip_dp.sv
// Datapath of the firmware configuration item port: selector, offset and entry stores.
`default_nettype none

module fcip_dp #(
    parameter int ENTRIES_PER_BANK = fcip_pkg::ENTRIES_PER_BANK_DEF,
    parameter int MAX_ENTRY_BYTES  = fcip_pkg::MAX_ENTRY_BYTES_DEF
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire fcip_pkg::request_t  request,
    input  wire fcip_pkg::dp_cmd_t   cmd,
    output fcip_pkg::dp_status_t     status,
    output fcip_pkg::result_t        result
);
    import fcip_pkg::*;

    localparam int SLOTS      = 2 * ENTRIES_PER_BANK;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OFF_W      = (MAX_ENTRY_BYTES > 1) ? $clog2(MAX_ENTRY_BYTES) : 1;
    localparam int ADDR_W     = SLOT_W + OFF_W;
    localparam int BYTE_DEPTH = SLOTS * (2 ** OFF_W);

    // Entry bytes live at {slot, offset}; slot records hold {writable, length}.
    logic [7:0] byte_mem [BYTE_DEPTH];
    logic [7:0] slot_mem [SLOTS];

    request_t          req_reg;
    logic [15:0]       sel_key_reg;
    logic [6:0]        offset_reg;
    logic [6:0]        len_q;
    logic              wr_ok_q;
    logic [7:0]        byte_q;
    logic              rd_ok_reg;
    result_t           result_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    logic [SLOT_W-1:0] sel_slot;
    logic [SLOT_W-1:0] req_slot;
    logic              sel_ok;
    logic              req_ok;
    logic [ADDR_W-1:0] sel_addr;
    logic              wr_go;
    logic              rd_go;
    logic              load_go;
    logic              len_go;
    logic [6:0]        offset_inc;
    logic [6:0]        sat_len;

    function automatic logic key_in_range(input logic [15:0] key);
        return 32'(key & KEY_INDEX_MASK) < 32'(ENTRIES_PER_BANK);
    endfunction

    function automatic logic [SLOT_W-1:0] slot_of(input logic [15:0] key);
        logic [SLOT_W-1:0] base;
        base = ((key & KEY_ARCH_BIT) != 16'h0) ? SLOT_W'(ENTRIES_PER_BANK) : '0;
        return base + SLOT_W'(key & KEY_INDEX_MASK);
    endfunction

    always_comb
    begin
        sel_slot   = slot_of(sel_key_reg);
        req_slot   = slot_of(req_reg.key);
        sel_ok     = (sel_key_reg != KEY_INVALID) && key_in_range(sel_key_reg);
        req_ok     = key_in_range(req_reg.key);
        sel_addr   = {sel_slot, OFF_W'(offset_reg)};
        offset_inc = offset_reg + 7'd1;
        rd_go      = sel_ok && (len_q != 7'd0) && (offset_reg < len_q);
        wr_go      = cmd.exec && (req_reg.mode == MODE_WRITE) && sel_ok
                     && ((sel_key_reg & KEY_WRITE_BIT) != 16'h0) && wr_ok_q
                     && (offset_reg < len_q);
        load_go    = cmd.exec && (req_reg.mode == MODE_LOAD) && req_ok
                     && (32'(req_reg.load_offset) < 32'(MAX_ENTRY_BYTES));
        len_go     = cmd.exec && (req_reg.mode == MODE_LENGTH) && req_ok;
        if (32'(req_reg.entry_length) > 32'(MAX_ENTRY_BYTES))
        begin
            sat_len = 7'(MAX_ENTRY_BYTES);
        end
        else
        begin
            sat_len = req_reg.entry_length;
        end
    end

    // Entry stores: one write port each, registered reads at the selected entry.
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            byte_mem[clr_cnt_reg] <= 8'h00;
        end
        else if (wr_go)
        begin
            byte_mem[sel_addr] <= req_reg.data_byte;
        end
        else if (load_go)
        begin
            byte_mem[{req_slot, OFF_W'(req_reg.load_offset)}] <= req_reg.data_byte;
        end

        if (cmd.clear && (clr_cnt_reg[OFF_W-1:0] == '0))
        begin
            slot_mem[clr_cnt_reg[ADDR_W-1:OFF_W]] <= 8'h00;
        end
        else if (len_go)
        begin
            slot_mem[req_slot] <= {req_reg.entry_writable, sat_len};
        end

        byte_q           <= byte_mem[sel_addr];
        {wr_ok_q, len_q} <= slot_mem[sel_slot];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= request;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_key_reg <= 16'h0000;
            offset_reg  <= 7'd0;
            rd_ok_reg   <= 1'b0;
            clr_cnt_reg <= '0;
            result_reg  <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
            end

            if (cmd.exec)
            begin
                unique case (req_reg.mode)
                    MODE_SELECT:
                    begin
                        result_reg  <= '0;
                        offset_reg  <= 7'd0;
                        sel_key_reg <= key_in_range(req_reg.key) ? req_reg.key : KEY_INVALID;
                    end
                    MODE_READ:
                    begin
                        result_reg <= '0;
                        rd_ok_reg  <= rd_go;
                        if (rd_go)
                        begin
                            offset_reg <= offset_inc;
                        end
                    end
                    MODE_WRITE:
                    begin
                        if (wr_go && (offset_inc == len_q))
                        begin
                            offset_reg <= 7'd0;
                            result_reg <= {8'h00, 1'b1, sel_key_reg};
                        end
                        else
                        begin
                            result_reg <= '0;
                            if (wr_go)
                            begin
                                offset_reg <= offset_inc;
                            end
                        end
                    end
                    default:
                    begin
                        result_reg <= '0;
                    end
                endcase
            end

            if (cmd.finish_read)
            begin
                result_reg <= {(rd_ok_reg ? byte_q : 8'h00), 1'b0, 16'h0000};
            end
        end
    end

    assign status.clear_last = (clr_cnt_reg == ADDR_W'(BYTE_DEPTH - 1));
    assign status.is_read    = (req_reg.mode == MODE_READ);
    assign result            = result_reg;

endmodule

`default_nettype wire

FILE: rtl/firmware_config_item_port.sv
// Top level of the firmware configuration item port.
`default_nettype none

// Firmware configuration item port. A transfer is taken at a rising clock edge with start
// high and busy low; it carries one request (select key, data read, data write, host byte
// load or host length set). Every transfer yields exactly one result, shown on the result
// port for a single cycle with done high; the receiver cannot stall it, so it must take the
// result in that cycle. A data read passes from the accepting edge through the execute
// state and then the read state, which takes the registered read of the byte store; every
// other request gives its result from the execute state. After reset the block first sweeps
// the byte store and the entry length store, one byte address a cycle, over all
// 2 * ENTRIES_PER_BANK * 2**ceil(log2(MAX_ENTRY_BYTES)) byte addresses (4096 with the
// defaults), holding busy high the whole time. Entry bytes sit at a power-of-two stride
// per entry, so the byte store may be somewhat larger than the bytes actually addressable.
module firmware_config_item_port #(
    parameter int ENTRIES_PER_BANK = fcip_pkg::ENTRIES_PER_BANK_DEF,
    parameter int MAX_ENTRY_BYTES  = fcip_pkg::MAX_ENTRY_BYTES_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire fcip_pkg::request_t request,
    output logic                    busy,
    output logic                    done,
    output fcip_pkg::result_t       result
);
    import fcip_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // The controller sequences each transfer and the clearing sweep.
    fcip_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // The datapath holds the selector, the byte offset and both entry stores.
    fcip_dp #(
        .ENTRIES_PER_BANK (ENTRIES_PER_BANK),
        .MAX_ENTRY_BYTES  (MAX_ENTRY_BYTES)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .status  (status),
        .result  (result)
    );

endmodule

`default_nettype wire

FILE: tb/sv/fcip_checker.sv
// Checker of the firmware configuration item port: predicts each result and compares it.
`default_nettype none

module fcip_checker
    import fcip_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire logic     busy,
    input  wire request_t request,
    input  wire logic     done,
    input  wire result_t  result,
    output int            errors,
    output int            pending
);

    localparam int BANK_SIZE = ENTRIES_PER_BANK_DEF;
    localparam int ENTRY_MAX = MAX_ENTRY_BYTES_DEF;
    localparam int SLOTS     = 2 * BANK_SIZE;

    // Shadow copy of the block's entry store and selector state.
    logic [7:0]  shadow_bytes [0:SLOTS*ENTRY_MAX-1];
    logic [6:0]  shadow_len   [0:SLOTS-1];
    logic        shadow_wr_ok [0:SLOTS-1];
    logic [15:0] shadow_key;
    logic [6:0]  shadow_offset;

    result_t expected_results [$];

    initial errors = 0;
    initial pending = 0;

    task automatic log_mismatch(input string what, input int got, input int want);
        $display("checker: %s mismatch, got %0h, want %0h, at %0t", what, got, want, $time);
        errors++;
    endtask

    // Returns 1 and the slot number when the key's index lies inside a bank.
    function automatic logic key_slot(input logic [15:0] k, output int slot);
        int idx;
        idx = int'(k & KEY_INDEX_MASK);
        slot = (k[15] ? BANK_SIZE : 0) + idx;
        return idx < BANK_SIZE;
    endfunction

    // Applies one request to the shadow state and returns the result it causes.
    function automatic result_t apply_request(input request_t r);
        result_t res;
        int      slot;
        int      req_slot;
        logic    sel_ok;
        logic    req_ok;
        logic [6:0] clipped;
        res = '0;
        sel_ok = (shadow_key != KEY_INVALID) && key_slot(shadow_key, slot);
        req_ok = key_slot(r.key, req_slot);
        case (r.mode)
            MODE_SELECT:
            begin
                shadow_offset = '0;
                shadow_key = req_ok ? r.key : KEY_INVALID;
            end
            MODE_READ:
            begin
                if (sel_ok && shadow_len[slot] != 0 && shadow_offset < shadow_len[slot])
                begin
                    res.read_data = shadow_bytes[slot*ENTRY_MAX + int'(shadow_offset)];
                    shadow_offset++;
                end
            end
            MODE_WRITE:
            begin
                if (sel_ok && (shadow_key & KEY_WRITE_BIT) != 0 && shadow_wr_ok[slot]
                    && shadow_offset < shadow_len[slot])
                begin
                    shadow_bytes[slot*ENTRY_MAX + int'(shadow_offset)] = r.data_byte;
                    shadow_offset++;
                    if (shadow_offset == shadow_len[slot])
                    begin
                        res.write_complete = 1'b1;
                        res.complete_key = shadow_key;
                        shadow_offset = '0;
                    end
                end
            end
            MODE_LOAD:
            begin
                if (req_ok && int'(r.load_offset) < ENTRY_MAX)
                    shadow_bytes[req_slot*ENTRY_MAX + int'(r.load_offset)] = r.data_byte;
            end
            MODE_LENGTH:
            begin
                if (req_ok)
                begin
                    clipped = (int'(r.entry_length) > ENTRY_MAX) ? 7'(ENTRY_MAX)
                                                                 : r.entry_length;
                    shadow_len[req_slot] = clipped;
                    shadow_wr_ok[req_slot] = r.entry_writable;
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS*ENTRY_MAX; i++)
                shadow_bytes[i] = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                shadow_len[i] = '0;
                shadow_wr_ok[i] = 1'b0;
            end
            shadow_key = '0;
            shadow_offset = '0;
            expected_results.delete();
            pending = 0;
        end
        else
        begin
            if (done)
            begin
                if (expected_results.size() == 0)
                    log_mismatch("unexpected result", int'(result), 0);
                else
                begin
                    result_t want;
                    want = expected_results.pop_front();
                    if (result.read_data !== want.read_data)
                        log_mismatch("read_data", int'(result.read_data),
                                     int'(want.read_data));
                    if (result.write_complete !== want.write_complete)
                        log_mismatch("write_complete", int'(result.write_complete),
                                     int'(want.write_complete));
                    if (result.complete_key !== want.complete_key)
                        log_mismatch("complete_key", int'(result.complete_key),
                                     int'(want.complete_key));
                end
            end
            if (start && !busy)
                expected_results.push_back(apply_request(request));
            pending = expected_results.size();
        end
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb.sv
// Testbench top of the firmware configuration item port: stimulus, run limit and verdict.
`default_nettype none

module tb;

    import fcip_pkg::*;

    logic     clk;
    logic     rst_n;
    logic     start;
    request_t request;
    wire      busy;
    wire      done;
    result_t  result;
    int       errors;
    int       pending;

    // Number of transfers taken so far, and whether the sender idles between them.
    int       sent;
    logic     no_idle;

    firmware_config_item_port dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .done    (done),
        .result  (result)
    );

    // The checker sits beside the block, watching both channels. It owns the prediction
    // and the comparison; this module only makes stimulus and reads back the error and
    // outstanding-result counts.
    fcip_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result),
        .errors  (errors),
        .pending (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run limit. It is set far above the length of a correct run, which is the clearing
    // pass after reset followed by the roughly 700 transfers and their sender gaps.
    initial
    begin
        #3200000;
        $display("tb: done, errors");
        $finish;
    end

    // Builds one request from its fields.
    function automatic request_t make_req(input logic [2:0] m, input logic [15:0] k,
                                          input logic [7:0] d, input logic [5:0] o,
                                          input logic [6:0] l, input logic w);
        request_t r;
        r.mode = m;
        r.key = k;
        r.data_byte = d;
        r.load_offset = o;
        r.entry_length = l;
        r.entry_writable = w;
        return r;
    endfunction

    // A key that names an entry in range. Low indexes are favored so that host setup,
    // reads and writes keep landing on the same few entries; now and then the index is
    // drawn from the whole bank, up to its top index, to hit the range edge.
    function automatic logic [15:0] entry_key(input logic write_ch);
        logic [15:0] k;
        k = '0;
        k[15] = 1'($urandom_range(0, 1));
        k[14] = write_ch;
        if ($urandom_range(0, 9) < 7)
            k[4:0] = 5'($urandom_range(0, 7));
        else
            k[4:0] = 5'($urandom_range(0, ENTRIES_PER_BANK_DEF - 1));
        return k;
    endfunction

    // Sender gap in cycles: mostly none, sometimes a few, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Offers one request and holds it until the block takes it. The task is entered and
    // left at a falling edge. When no gap is wanted, start simply stays high, so it never
    // gets two assignments in one time step.
    task automatic issue(input request_t r);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        request <= r;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // Holds off the sender until every expected result has come back.
    task automatic drain();
        start <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    // A host setup sequence: set an entry's length and writable mark, then load a few of
    // its bytes. Lengths are mostly short, with full-size, oversized and absent ones mixed in.
    task automatic host_setup();
        logic [15:0] k;
        logic [6:0]  len;
        int          r;
        int          loads;
        k = entry_key(1'($urandom_range(0, 1)));
        r = $urandom_range(0, 99);
        if (r < 70)
            len = 7'($urandom_range(1, 8));
        else if (r < 85)
            len = 7'($urandom_range(9, 64));
        else if (r < 93)
            len = 7'($urandom_range(64, 127));
        else
            len = '0;
        issue(make_req(MODE_LENGTH, k, 8'($urandom), 6'($urandom), len,
                       1'($urandom_range(0, 3) != 0)));
        loads = $urandom_range(0, 8);
        for (int i = 0; i < loads; i++)
            issue(make_req(MODE_LOAD, k, 8'($urandom),
                           6'($urandom_range(0, (len > 8) ? 63 : 7)),
                           7'($urandom), 1'($urandom)));
    endtask

    // A guest read pass: select an entry, then read past its end now and then.
    task automatic read_pass();
        int n;
        issue(make_req(MODE_SELECT, entry_key(1'($urandom_range(0, 1))), 8'($urandom),
                       6'($urandom), 7'($urandom), 1'($urandom)));
        n = $urandom_range(1, 10);
        for (int i = 0; i < n; i++)
            issue(make_req(MODE_READ, 16'($urandom), 8'($urandom), 6'($urandom),
                           7'($urandom), 1'($urandom)));
    endtask

    // A guest write pass: select an entry through the write channel (mostly) and write
    // enough bytes to fill short entries, which raises the completion flag.
    task automatic write_pass();
        int n;
        issue(make_req(MODE_SELECT, entry_key(1'($urandom_range(0, 9) != 0)), 8'($urandom),
                       6'($urandom), 7'($urandom), 1'($urandom)));
        n = $urandom_range(1, 12);
        for (int i = 0; i < n; i++)
            issue(make_req(MODE_WRITE, 16'($urandom), 8'($urandom), 6'($urandom),
                           7'($urandom), 1'($urandom)));
    endtask

    initial
    begin
        int pick;
        int noise;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        sent = 0;
        no_idle = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. Every transfer yields one result, and the first one waits out the
        // clearing pass through busy.
        // Lengths: a short writable entry, an oversized length that saturates in the
        // architecture bank, and a length set on an index past the bank, which is ignored.
        issue(make_req(MODE_LENGTH, 16'h0000, 8'h00, 6'h00, 7'd3, 1'b1));
        issue(make_req(MODE_LENGTH, 16'h8005, 8'h00, 6'h00, 7'd127, 1'b0));
        issue(make_req(MODE_LENGTH, 16'h0020, 8'hff, 6'h3f, 7'd5, 1'b1));
        // Host loads: the last byte position, the first one, an out-of-range index, and a
        // key whose write-channel bit must be ignored.
        issue(make_req(MODE_LOAD, 16'h8005, 8'hff, 6'd63, 7'd0, 1'b0));
        issue(make_req(MODE_LOAD, 16'h8005, 8'ha5, 6'd0, 7'd0, 1'b0));
        issue(make_req(MODE_LOAD, 16'h3fff, 8'h77, 6'd1, 7'd0, 1'b0));
        issue(make_req(MODE_LOAD, 16'h4000, 8'h5a, 6'd0, 7'd0, 1'b0));
        // Read the first two bytes of the saturated entry.
        issue(make_req(MODE_SELECT, 16'h8005, 8'h00, 6'h00, 7'd0, 1'b0));
        issue(make_req(MODE_READ, 16'h0000, 8'h00, 6'h00, 7'd0, 1'b0));
        issue(make_req(MODE_READ, 16'h0000, 8'h00, 6'h00, 7'd0, 1'b0));
        // An invalid selector: reads give zero and writes are dropped.
        issue(make_req(MODE_SELECT, 16'hffff, 8'hff, 6'h3f, 7'h7f, 1'b1));
        issue(make_req(MODE_READ, 16'h0000, 8'h00, 6'h00, 7'd0, 1'b0));
        issue(make_req(MODE_WRITE, 16'h0000, 8'h99, 6'h00, 7'd0, 1'b0));
        // A write without the write channel is refused.
        issue(make_req(MODE_SELECT, 16'h0000, 8'h00, 6'h00, 7'd0, 1'b0));
        issue(make_req(MODE_WRITE, 16'h0000, 8'h99, 6'h00, 7'd0, 1'b0));
        // Fill the three-byte entry through the write channel; the last byte completes it.
        issue(make_req(MODE_SELECT, 16'h4000, 8'h00, 6'h00, 7'd0, 1'b0));
        issue(make_req(MODE_WRITE, 16'h0000, 8'h11, 6'h00, 7'd0, 1'b0));
        issue(make_req(MODE_WRITE, 16'h0000, 8'h22, 6'h00, 7'd0, 1'b0));
        issue(make_req(MODE_WRITE, 16'h0000, 8'h33, 6'h00, 7'd0, 1'b0));
        // A non-writable entry refuses writes even through the write channel.
        issue(make_req(MODE_SELECT, 16'hc005, 8'h00, 6'h00, 7'd0, 1'b0));
        issue(make_req(MODE_WRITE, 16'h0000, 8'h44, 6'h00, 7'd0, 1'b0));
        // An absent entry reads as zero.
        issue(make_req(MODE_SELECT, 16'h001f, 8'h00, 6'h00, 7'd0, 1'b0));
        issue(make_req(MODE_READ, 16'h0000, 8'h00, 6'h00, 7'd0, 1'b0));
        // The unused modes do nothing but still give a result.
        issue(make_req(3'd5, 16'h0001, 8'h12, 6'h01, 7'd1, 1'b1));
        issue(make_req(3'd7, 16'hffff, 8'hff, 6'h3f, 7'h7f, 1'b1));
        drain();

        // Random part: mostly well-formed host and guest sequences, some noise. Bursts
        // without idling alternate with idling stretches, and now and then the sender
        // waits until the block has answered everything.
        while (sent < 700)
        begin
            no_idle = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 25)
                host_setup();
            else if (pick < 50)
                read_pass();
            else if (pick < 80)
                write_pass();
            else
            begin
                noise = $urandom_range(1, 3);
                for (int i = 0; i < noise; i++)
                    issue(make_req(3'($urandom), 16'($urandom), 8'($urandom),
                                   6'($urandom), 7'($urandom), 1'($urandom)));
            end
            if ($urandom_range(0, 19) == 0)
                drain();
        end

        // All transfers are in: wait for the last results, then a few more cycles so that
        // a stray result would still be seen.
        drain();
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
